>>> design/acpu_pkg.sv
package acpu_pkg;

  localparam int RamAddrBitsDefault = 15;
  localparam int ByteBits           = 8;
  localparam logic [15:0] PageMask  = 16'hff00;

  typedef enum logic [2:0] {
    OpLd  = 3'd0,
    OpAnd = 3'd1,
    OpOr  = 3'd2,
    OpXor = 3'd3,
    OpAdd = 3'd4,
    OpSub = 3'd5,
    OpSt  = 3'd6,
    OpJmp = 3'd7
  } op_e;

  // address / destination for everything except jumps
  typedef enum logic [2:0] {
    ModeDAc      = 3'd0,
    ModeXAc      = 3'd1,
    ModeYdAc     = 3'd2,
    ModeYxAc     = 3'd3,
    ModeDX       = 3'd4,
    ModeDY       = 3'd5,
    ModeDOut     = 3'd6,
    ModeYxIncOut = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    SrcD   = 2'd0,
    SrcRam = 2'd1,
    SrcAc  = 2'd2,
    SrcIn  = 2'd3
  } src_e;

  // jump mode zero is the far jump, other modes are a condition mask
  localparam logic [2:0] JmpFar = 3'd0;
  localparam logic [1:0] CondGt = 2'd0;
  localparam logic [1:0] CondLt = 2'd1;
  localparam logic [1:0] CondEq = 2'd2;

  function automatic logic [15:0] operand_addr(logic [7:0] instr, logic [7:0] d,
                                               logic [7:0] x, logic [7:0] y);
    logic [7:0] lo;
    logic [7:0] hi;
    mode_e      m;
    logic       jmp;
    m   = mode_e'(instr[4:2]);
    jmp = (op_e'(instr[7:5]) == OpJmp);
    lo  = d;
    hi  = '0;
    if (!jmp) begin
      if (m == ModeXAc || m == ModeYxAc || m == ModeYxIncOut) begin
        lo = x;
      end
      if (m == ModeYdAc || m == ModeYxAc || m == ModeYxIncOut) begin
        hi = y;
      end
    end
    return {hi, lo};
  endfunction

endpackage

>>> design/acpu_item_if.sv
interface acpu_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] instruction_byte;
  logic [7:0] data_byte;
  logic [7:0] input_port;

  modport source (output valid, output instruction_byte, output data_byte,
                  output input_port, input ready);
  modport sink (input valid, input instruction_byte, input data_byte,
                input input_port, output ready);
endinterface

>>> design/acpu_result_if.sv
interface acpu_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] fetch_address;
  logic [7:0]  output_port;
  logic [7:0]  accumulator;

  modport source (output valid, output fetch_address, output output_port,
                  output accumulator, input ready);
  modport sink (input valid, input fetch_address, input output_port,
                input accumulator, output ready);
endinterface

>>> design/eight_bit_accumulator_cpu_tick.sv
// channel    dir  payload                                         handshake
// item_i     in   instruction_byte, data_byte, input_port         valid/ready
// result_o   out  fetch_address, output_port, accumulator         valid/ready
// cfg        in   cfg_data_i (floating bus value)                 cfg_we_i
//
// one tick per cycle when not stalled: ram operand read is issued when the
// previous tick is taken, so execution works on the registered read data.
// after reset the ram is swept to zero, all 2^RAM_ADDR_BITS words (32768 by
// default), with item_i.ready low; cfg writes are taken throughout.
// result_o is an output register; a stalled result blocks new ticks only
// until it is taken, and a tick can enter in the cycle the result leaves.
module eight_bit_accumulator_cpu_tick #(
  parameter int RAM_ADDR_BITS = acpu_pkg::RamAddrBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_data_i,
  acpu_item_if.sink            item_i,
  acpu_result_if.source        result_o
);

  localparam int RamDepth = 1 << RAM_ADDR_BITS;

  logic [7:0]  ram_q [RamDepth];
  logic [7:0]  ram_rd_q;

  logic [15:0] pc_q, pc_d;
  logic [7:0]  op_q, opd_q;
  logic [7:0]  ac_q, ac_d;
  logic [7:0]  x_q, x_d;
  logic [7:0]  y_q, y_d;
  logic [7:0]  out_q, out_d;
  logic [7:0]  float_q;

  logic                     clr_busy_q;
  logic [RAM_ADDR_BITS-1:0] clr_addr_q;

  logic       byp_sel_q;
  logic [7:0] byp_data_q;

  logic        res_valid_q;
  logic [15:0] res_pc_q;
  logic [7:0]  res_out_q;
  logic [7:0]  res_ac_q;

  acpu_pkg::op_e   op;
  acpu_pkg::mode_e mode;
  acpu_pkg::src_e  src;
  logic            is_st;
  logic            is_jmp;
  logic            accept;
  logic [7:0]      ram_data;
  logic [7:0]      bus;
  logic [7:0]      alu;
  logic [1:0]      cond_sel;
  logic [15:0]     exec_addr_full;
  logic [15:0]     next_addr_full;
  logic [RAM_ADDR_BITS-1:0] exec_addr;
  logic [RAM_ADDR_BITS-1:0] next_addr;
  logic            ram_we;
  logic [RAM_ADDR_BITS-1:0] ram_waddr;
  logic [7:0]      ram_wdata;
  logic            byp_hit;

  assign item_i.ready = !clr_busy_q && (!res_valid_q || result_o.ready);
  assign accept       = item_i.valid && item_i.ready;

  assign op     = acpu_pkg::op_e'(op_q[7:5]);
  assign mode   = acpu_pkg::mode_e'(op_q[4:2]);
  assign src    = acpu_pkg::src_e'(op_q[1:0]);
  assign is_st  = (op == acpu_pkg::OpSt);
  assign is_jmp = (op == acpu_pkg::OpJmp);

  assign exec_addr_full = acpu_pkg::operand_addr(op_q, opd_q, x_q, y_q);
  assign exec_addr      = exec_addr_full[RAM_ADDR_BITS-1:0];

  // a store in this tick to the address read for the next one is forwarded
  assign ram_data = byp_sel_q ? byp_data_q : ram_rd_q;

  always_comb begin
    case (src)
      acpu_pkg::SrcD:   bus = opd_q;
      acpu_pkg::SrcRam: bus = is_st ? float_q : ram_data;
      acpu_pkg::SrcAc:  bus = ac_q;
      acpu_pkg::SrcIn:  bus = item_i.input_port;
      default:          bus = opd_q;
    endcase
  end

  always_comb begin
    case (op)
      acpu_pkg::OpLd:  alu = bus;
      acpu_pkg::OpAnd: alu = ac_q & bus;
      acpu_pkg::OpOr:  alu = ac_q | bus;
      acpu_pkg::OpXor: alu = ac_q ^ bus;
      acpu_pkg::OpAdd: alu = ac_q + bus;
      acpu_pkg::OpSub: alu = ac_q - bus;
      acpu_pkg::OpSt:  alu = ac_q;
      acpu_pkg::OpJmp: alu = 8'd0 - ac_q;
      default:         alu = bus;
    endcase
  end

  always_comb begin
    ac_d  = ac_q;
    x_d   = x_q;
    y_d   = y_q;
    out_d = out_q;
    if (!is_jmp) begin
      case (mode)
        acpu_pkg::ModeDX: x_d = alu;
        acpu_pkg::ModeDY: y_d = alu;
        acpu_pkg::ModeDOut, acpu_pkg::ModeYxIncOut: begin
          if (!is_st) out_d = alu;
        end
        default: begin
          if (!is_st) ac_d = alu;
        end
      endcase
      if (mode == acpu_pkg::ModeYxIncOut) begin
        x_d = x_q + 8'd1;
      end
    end
  end

  always_comb begin
    if (ac_q == 8'd0) begin
      cond_sel = acpu_pkg::CondEq;
    end else if (ac_q[7]) begin
      cond_sel = acpu_pkg::CondLt;
    end else begin
      cond_sel = acpu_pkg::CondGt;
    end
    pc_d = pc_q + 16'd1;
    if (is_jmp) begin
      if (op_q[4:2] == acpu_pkg::JmpFar) begin
        pc_d = {y_q, bus};
      end else if (op_q[2 + cond_sel]) begin
        pc_d = (pc_q & acpu_pkg::PageMask) | {8'h00, bus};
      end
    end
  end

  // operand address of the instruction coming in, using the updated indexes
  assign next_addr_full = acpu_pkg::operand_addr(item_i.instruction_byte, item_i.data_byte,
                                                 x_d, y_d);
  assign next_addr      = next_addr_full[RAM_ADDR_BITS-1:0];

  assign ram_we    = clr_busy_q || (accept && is_st);
  assign ram_waddr = clr_busy_q ? clr_addr_q : exec_addr;
  assign ram_wdata = clr_busy_q ? 8'd0 : bus;
  assign byp_hit   = is_st && (exec_addr == next_addr);

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ram_q[ram_waddr] <= ram_wdata;
    end
    if (accept) begin
      ram_rd_q <= ram_q[next_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      op_q        <= '0;
      opd_q       <= '0;
      ac_q        <= '0;
      x_q         <= '0;
      y_q         <= '0;
      out_q       <= '0;
      float_q     <= '0;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      byp_sel_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        float_q <= cfg_data_i;
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + RAM_ADDR_BITS'(1);
        if (&clr_addr_q) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (accept) begin
        pc_q      <= pc_d;
        op_q      <= item_i.instruction_byte;
        opd_q     <= item_i.data_byte;
        ac_q      <= ac_d;
        x_q       <= x_d;
        y_q       <= y_d;
        out_q     <= out_d;
        byp_sel_q <= byp_hit;
      end
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byp_data_q <= bus;
      res_pc_q   <= pc_d;
      res_out_q  <= out_d;
      res_ac_q   <= ac_d;
    end
  end

  assign result_o.valid         = res_valid_q;
  assign result_o.fetch_address = res_pc_q;
  assign result_o.output_port   = res_out_q;
  assign result_o.accumulator   = res_ac_q;

endmodule
